### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the scheduler block.
// Stand-alone header; no other dependency.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PTPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define PTPS_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

### rtl/core/ptps_pkg.sv
// Shared types and constants of the priority task scheduler.
// No dependencies; used by the slot cell, the top level and the checker.
package ptps_pkg;

  localparam int SLOTS  = 16;
  localparam int PRIO_W = 2;
  localparam int ID_W   = 16;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int OCNT_W = 5;

  localparam logic [PRIO_W-1:0] PRIO_RESET = PRIO_W'(1);
  localparam logic [ID_W-1:0]   ID_FIRST   = ID_W'(1);

  typedef enum logic [2:0] {
    ACT_CREATE    = 3'd0,
    ACT_TERMINATE = 3'd1,
    ACT_SUSPEND   = 3'd2,
    ACT_RESUME    = 3'd3,
    ACT_SET_PRIO  = 3'd4,
    ACT_SCHEDULE  = 3'd5,
    ACT_YIELD     = 3'd6,
    ACT_SLEEP     = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BLOCKED = 2'd2
  } slot_state_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] task_id;
    logic [1:0]  new_priority;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] result_id;
    logic [4:0]  running_count;
    logic [4:0]  blocked_count;
    logic [4:0]  live_count;
  } out_word_t;

  // Record that walks down the row of slot cells, one cell per cycle.
  typedef struct packed {
    logic              free_ok;
    logic [IDX_W-1:0]  free_idx;
    logic              hit_ok;
    logic [IDX_W-1:0]  hit_idx;
    logic [RANK_W-1:0] hit_rank;
    slot_state_t       hit_state;
    logic              pick_ok;
    logic [IDX_W-1:0]  pick_idx;
    logic [PRIO_W-1:0] pick_prio;
    logic [RANK_W-1:0] pick_rank;
    logic [ID_W-1:0]   pick_id;
    logic              cur_ok;
    logic              cur_run;
    logic [ID_W-1:0]   cur_id;
    logic [CNT_W-1:0]  n_run;
    logic [CNT_W-1:0]  n_blk;
    logic [CNT_W-1:0]  n_live;
  } scan_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    action_t           action;
    logic [ID_W-1:0]   task_id;
    logic              cur_valid;
    logic [IDX_W-1:0]  cur_idx;
    logic              create_en;
    logic              kill_en;
    logic              block_en;
    logic              ready_en;
    logic              prio_en;
    logic              sched_en;
    logic [IDX_W-1:0]  tgt_idx;
    logic [RANK_W-1:0] tgt_rank;
    logic [ID_W-1:0]   new_id;
    logic [PRIO_W-1:0] new_prio;
    logic [RANK_W-1:0] new_rank;
    logic              pick_ok;
    logic [IDX_W-1:0]  pick_idx;
  } ctl_t;

endpackage

### rtl/core/ptps_cell.sv
// One task slot of the scheduler table and its stage of the search row.
// Depends on ptps_pkg.
module ptps_cell #(
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  ptps_pkg::ctl_t  ctl,
  input  ptps_pkg::scan_t scan_in,
  output ptps_pkg::scan_t scan_out
);

  localparam int IW = ptps_pkg::IDX_W;
  localparam int RW = ptps_pkg::RANK_W;
  localparam int CW = ptps_pkg::CNT_W;
  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic                          used;
  logic [ptps_pkg::ID_W-1:0]     id;
  ptps_pkg::slot_state_t         st;
  logic [ptps_pkg::PRIO_W-1:0]   prio;
  logic [RW-1:0]                 rank;

  logic                  is_cur;
  logic                  is_tgt;
  ptps_pkg::slot_state_t st_eff;
  ptps_pkg::slot_state_t st_sched;
  ptps_pkg::scan_t       scan_next;

  // Yield and sleep see the running current task as already ready or blocked.
  always_comb begin
    is_cur = ctl.cur_valid && (ctl.cur_idx == MY_IDX);
    is_tgt = (ctl.tgt_idx == MY_IDX);
    st_eff = st;
    if (is_cur && used && st == ptps_pkg::ST_RUNNING) begin
      if (ctl.action == ptps_pkg::ACT_YIELD) begin
        st_eff = ptps_pkg::ST_READY;
      end else if (ctl.action == ptps_pkg::ACT_SLEEP) begin
        st_eff = ptps_pkg::ST_BLOCKED;
      end
    end
  end

  always_comb begin
    scan_next = scan_in;
    if (!scan_in.free_ok && !used) begin
      scan_next.free_ok  = 1'b1;
      scan_next.free_idx = MY_IDX;
    end
    // Oldest live task wins when ids repeat after a wrap.
    if (used && id == ctl.task_id && (!scan_in.hit_ok || rank < scan_in.hit_rank)) begin
      scan_next.hit_ok    = 1'b1;
      scan_next.hit_idx   = MY_IDX;
      scan_next.hit_rank  = rank;
      scan_next.hit_state = st;
    end
    if (used && st_eff == ptps_pkg::ST_READY &&
        (!scan_in.pick_ok || prio > scan_in.pick_prio ||
         (prio == scan_in.pick_prio && rank < scan_in.pick_rank))) begin
      scan_next.pick_ok   = 1'b1;
      scan_next.pick_idx  = MY_IDX;
      scan_next.pick_prio = prio;
      scan_next.pick_rank = rank;
      scan_next.pick_id   = id;
    end
    if (is_cur) begin
      scan_next.cur_ok  = used;
      scan_next.cur_run = used && st_eff == ptps_pkg::ST_RUNNING;
      scan_next.cur_id  = id;
    end
    scan_next.n_live = scan_in.n_live + CW'(used);
    scan_next.n_run  = scan_in.n_run + CW'(used && st_eff == ptps_pkg::ST_RUNNING);
    scan_next.n_blk  = scan_in.n_blk + CW'(used && st_eff == ptps_pkg::ST_BLOCKED);
  end

  // Picked task runs; a displaced running current task drops back to ready.
  always_comb begin
    if (ctl.pick_ok && ctl.pick_idx == MY_IDX) begin
      st_sched = ptps_pkg::ST_RUNNING;
    end else if (ctl.pick_ok && is_cur && st_eff == ptps_pkg::ST_RUNNING) begin
      st_sched = ptps_pkg::ST_READY;
    end else begin
      st_sched = st_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctl.create_en && is_tgt) begin
      used <= 1'b1;
    end else if (ctl.kill_en && is_tgt) begin
      used <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
    if (ctl.create_en && is_tgt) begin
      id   <= ctl.new_id;
      st   <= ptps_pkg::ST_READY;
      prio <= ctl.new_prio;
      rank <= ctl.new_rank;
    end
    // Close up the ranks of younger tasks.
    if (ctl.kill_en && used && rank > ctl.tgt_rank) begin
      rank <= rank - RW'(1);
    end
    if (ctl.block_en && is_tgt) begin
      st <= ptps_pkg::ST_BLOCKED;
    end
    if (ctl.ready_en && is_tgt) begin
      st <= ptps_pkg::ST_READY;
    end
    if (ctl.prio_en && is_tgt) begin
      prio <= ctl.new_prio;
    end
    if (ctl.sched_en) begin
      st <= st_sched;
    end
  end

endmodule

### rtl/core/process_table_priority_scheduler.sv
// Top level of the priority task scheduler: controller plus a row of slot cells.
// Depends on ptps_pkg and ptps_cell.
// A word is taken only while the block is idle. The search record then walks the row of slot
// cells (free slot, id lookup, schedule pick and state counts all gathered in that one walk), and
// the apply state commits the table update and loads the output register with the result in
// the same cycle, after which the block returns to idle.
// The input is stalled while a word is in progress. A finished result waits in the output
// register without holding up acceptance of the next word, but that word's commit cycle
// waits until the output register is free. The default priority register may be written at
// any time the block is idle and resets to 1.
module process_table_priority_scheduler (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptps_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ptps_pkg::out_word_t out_data,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data
);

  localparam int N  = ptps_pkg::SLOTS;
  localparam int IW = ptps_pkg::IDX_W;
  localparam int RW = ptps_pkg::RANK_W;
  localparam int CW = ptps_pkg::CNT_W;
  localparam int OW = ptps_pkg::OCNT_W;
  localparam int PW = ptps_pkg::PRIO_W;
  localparam int DW = ptps_pkg::ID_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t             state;
  logic [IW-1:0]      scan_cnt;
  ptps_pkg::in_word_t req;
  logic               cur_valid;
  logic [IW-1:0]      cur_idx;
  logic [DW-1:0]      next_id;
  logic [PW-1:0]      dflt_prio;

  ptps_pkg::scan_t    chain [N+1];
  ptps_pkg::scan_t    t;
  ptps_pkg::ctl_t     ctl;

  logic                 out_free;
  logic                 go;
  ptps_pkg::status_t    status_v;
  logic                 create_ok, kill_ok, block_ok, ready_ok, prio_ok, sched_op;
  logic [IW-1:0]        tgt_idx;
  logic [PW-1:0]        new_prio;
  logic [CW-1:0]        run_v, blk_v, live_v;
  logic                 cur_valid_v;
  logic [IW-1:0]        cur_idx_v;
  logic [DW-1:0]        rid_v;
  logic [DW-1:0]        nid_inc;

  assign chain[0] = '0;
  assign t        = chain[N];
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign go       = (state == S_APPLY) && out_free;

  for (genvar g = 0; g < N; g++) begin : g_cell
    ptps_cell #(
      .INDEX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .scan_in  (chain[g]),
      .scan_out (chain[g+1])
    );
  end

  always_comb begin
    nid_inc = next_id + DW'(1);
    if (nid_inc == '0) begin
      nid_inc = ptps_pkg::ID_FIRST;
    end
  end

  // Work out the outcome from the record that left the last cell.
  always_comb begin
    status_v    = ptps_pkg::STAT_OK;
    create_ok   = 1'b0;
    kill_ok     = 1'b0;
    block_ok    = 1'b0;
    ready_ok    = 1'b0;
    prio_ok     = 1'b0;
    sched_op    = 1'b0;
    tgt_idx     = t.hit_idx;
    new_prio    = dflt_prio;
    run_v       = t.n_run;
    blk_v       = t.n_blk;
    live_v      = t.n_live;
    cur_valid_v = cur_valid;
    cur_idx_v   = cur_idx;
    unique case (req.action) inside
      ptps_pkg::ACT_CREATE: begin
        if (t.free_ok) begin
          create_ok = 1'b1;
          tgt_idx   = t.free_idx;
          live_v    = t.n_live + CW'(1);
        end else begin
          status_v = ptps_pkg::STAT_FULL;
        end
      end
      ptps_pkg::ACT_TERMINATE: begin
        if (t.hit_ok) begin
          kill_ok = 1'b1;
          live_v  = t.n_live - CW'(1);
          if (t.hit_state == ptps_pkg::ST_RUNNING) begin
            run_v = t.n_run - CW'(1);
          end
          if (t.hit_state == ptps_pkg::ST_BLOCKED) begin
            blk_v = t.n_blk - CW'(1);
          end
          if (cur_valid && cur_idx == t.hit_idx) begin
            cur_valid_v = 1'b0;
          end
        end else begin
          status_v = ptps_pkg::STAT_BAD;
        end
      end
      ptps_pkg::ACT_SUSPEND: begin
        if (t.hit_ok && t.hit_state == ptps_pkg::ST_RUNNING) begin
          block_ok = 1'b1;
          run_v    = t.n_run - CW'(1);
          blk_v    = t.n_blk + CW'(1);
          if (cur_valid && cur_idx == t.hit_idx) begin
            cur_valid_v = 1'b0;
          end
        end else begin
          status_v = ptps_pkg::STAT_BAD;
        end
      end
      ptps_pkg::ACT_RESUME: begin
        if (t.hit_ok && t.hit_state == ptps_pkg::ST_BLOCKED) begin
          ready_ok = 1'b1;
          blk_v    = t.n_blk - CW'(1);
        end else begin
          status_v = ptps_pkg::STAT_BAD;
        end
      end
      ptps_pkg::ACT_SET_PRIO: begin
        new_prio = req.new_priority[PW-1:0];
        if (t.hit_ok) begin
          prio_ok = 1'b1;
        end else begin
          status_v = ptps_pkg::STAT_BAD;
        end
      end
      ptps_pkg::ACT_SCHEDULE, ptps_pkg::ACT_YIELD, ptps_pkg::ACT_SLEEP: begin
        sched_op = 1'b1;
        if (req.action == ptps_pkg::ACT_SLEEP) begin
          cur_valid_v = 1'b0;
        end
        if (t.pick_ok) begin
          // A displaced running task cancels the one that starts running.
          if (!t.cur_run) begin
            run_v = t.n_run + CW'(1);
          end
          cur_valid_v = 1'b1;
          cur_idx_v   = t.pick_idx;
        end
      end
    endcase

    if (create_ok) begin
      rid_v = next_id;
    end else if (status_v == ptps_pkg::STAT_FULL) begin
      rid_v = '0;
    end else if (sched_op && t.pick_ok) begin
      rid_v = t.pick_id;
    end else if (cur_valid_v && t.cur_ok) begin
      rid_v = t.cur_id;
    end else begin
      rid_v = '0;
    end
  end

  always_comb begin
    ctl.action    = req.action;
    ctl.task_id   = req.task_id;
    ctl.cur_valid = cur_valid;
    ctl.cur_idx   = cur_idx;
    ctl.create_en = go && create_ok;
    ctl.kill_en   = go && kill_ok;
    ctl.block_en  = go && block_ok;
    ctl.ready_en  = go && ready_ok;
    ctl.prio_en   = go && prio_ok;
    ctl.sched_en  = go && sched_op;
    ctl.tgt_idx   = tgt_idx;
    ctl.tgt_rank  = t.hit_rank;
    ctl.new_id    = next_id;
    ctl.new_prio  = new_prio;
    ctl.new_rank  = RW'(t.n_live);
    ctl.pick_ok   = t.pick_ok;
    ctl.pick_idx  = t.pick_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      cur_valid <= 1'b0;
      cur_idx   <= '0;
      next_id   <= ptps_pkg::ID_FIRST;
      dflt_prio <= ptps_pkg::PRIO_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dflt_prio <= cfg_wr_data[PW-1:0];
      end
      if (out_valid && !out_stall && !go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req      <= in_data;
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Hold until the record has passed the last cell.
          if (scan_cnt == IW'(N - 1)) begin
            state <= S_APPLY;
          end else begin
            scan_cnt <= scan_cnt + IW'(1);
          end
        end
        S_APPLY: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_data.status        <= status_v;
            out_data.result_id     <= rid_v;
            out_data.running_count <= OW'(run_v);
            out_data.blocked_count <= OW'(blk_v);
            out_data.live_count    <= OW'(live_v);
            cur_valid              <= cur_valid_v;
            cur_idx                <= cur_idx_v;
            if (create_ok) begin
              next_id <= nid_inc;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/ptps_checker.sv
// Port-level checks of the priority task scheduler, bound to its top level.
// Depends on ptps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptps_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input ptps_pkg::out_word_t out_data
);

  `PTPS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result word changed or dropped")
  `PTPS_ASSERT(a_one_running, clk, rst, out_valid |-> out_data.running_count <= 5'd1, "more than one task running")
  `PTPS_ASSERT(a_counts_fit, clk, rst, out_valid |-> ({1'b0, out_data.running_count} + {1'b0, out_data.blocked_count} <= {1'b0, out_data.live_count}), "running plus blocked exceeds live tasks")
  `PTPS_ASSERT(a_full_table, clk, rst, out_valid && out_data.status == ptps_pkg::STAT_FULL |-> out_data.result_id == 16'd0 && out_data.live_count == 5'(ptps_pkg::SLOTS), "table full reported with free slots or an id")
  `PTPS_ASSERT_NEVER(a_live_bound, clk, rst, out_valid && out_data.live_count > 5'(ptps_pkg::SLOTS), "live count beyond table size")

endmodule

bind process_table_priority_scheduler ptps_checker u_ptps_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
